/* hw/rtl/lfmc_pkg.sv */
// Shared types and constants for the line follower motor control unit.
package lfmc_pkg;

    // Drive mode reported with each result
    typedef enum logic [1:0] {
        MODE_CRUISE = 2'd0,
        MODE_TURN   = 2'd1,
        MODE_SPIN   = 2'd2
    } t_mode;

    // Sensor patterns, written {left, middle, right}
    localparam logic [2:0] PAT_LOST        = 3'b000;
    localparam logic [2:0] PAT_RIGHT_SOFT  = 3'b001;
    localparam logic [2:0] PAT_RIGHT_SHARP = 3'b011;
    localparam logic [2:0] PAT_LEFT_SOFT   = 3'b100;
    localparam logic [2:0] PAT_LEFT_SHARP  = 3'b110;

    // Configuration register indexes
    localparam logic [0:0] REG_PWM_PERIOD     = 1'b0;
    localparam logic [0:0] REG_RESUME_PERCENT = 1'b1;

    // Register reset values
    localparam logic [15:0] PWM_PERIOD_RST     = 16'd1000;
    localparam logic [6:0]  RESUME_PERCENT_RST = 7'd80;

    // Fixed duty percents
    localparam logic [6:0] PCT_FULL  = 7'd100;
    localparam logic [6:0] PCT_NINE  = 7'd90;
    localparam logic [6:0] PCT_HALF  = 7'd50;
    localparam logic [6:0] PCT_TENTH = 7'd10;
    localparam logic [6:0] PCT_ZERO  = 7'd0;
    localparam logic [6:0] PCT_RAMP_TOP = 7'd100;

    // Divide by 100 via reciprocal: floor(x / 100) = (x * RECIP) >> SHIFT,
    // exact for x < 2^30 / 76, which covers every 16 x 7 bit product.
    localparam int          DIV_SHIFT = 30;
    localparam logic [23:0] DIV_RECIP = 24'd10737419;

    // Per-channel duty percents from the decode stage
    typedef struct packed {
        logic [6:0] lf;
        logic [6:0] lr;
        logic [6:0] rf;
        logic [6:0] rr;
    } t_pct_set;

    // Stage load strobes handed to the duty lanes
    typedef struct packed {
        logic load_prod;
        logic load_duty;
    } t_lane_ctl;

endpackage

/* hw/rtl/lfmc_decode.sv */
// Sensor pattern decode, drive state and per-channel percent selection.
module lfmc_decode (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic                i_sensor_left,
    input  logic                i_sensor_middle,
    input  logic                i_sensor_right,
    input  logic [6:0]          i_resume_percent,
    output lfmc_pkg::t_pct_set  o_pct,
    output lfmc_pkg::t_mode     o_mode
);

    logic               r_turn_memory;
    logic               r_recovering;
    logic [6:0]         r_speed_percent;
    logic               n_turn_memory;
    logic               n_recovering;
    logic [6:0]         n_speed_percent;
    lfmc_pkg::t_pct_set r_pct;
    lfmc_pkg::t_pct_set n_pct;
    lfmc_pkg::t_mode    r_mode;
    lfmc_pkg::t_mode    n_mode;
    logic [2:0]         w_pat;
    logic               w_right_pat;
    logic               w_left_pat;

    assign w_pat       = {i_sensor_left, i_sensor_middle, i_sensor_right};
    assign w_right_pat = (w_pat == lfmc_pkg::PAT_RIGHT_SHARP) ||
                         (w_pat == lfmc_pkg::PAT_RIGHT_SOFT);
    assign w_left_pat  = (w_pat == lfmc_pkg::PAT_LEFT_SHARP) ||
                         (w_pat == lfmc_pkg::PAT_LEFT_SOFT);

    // Pick channel percents and next drive state
    always_comb begin
        n_turn_memory   = r_turn_memory;
        n_recovering    = r_recovering;
        n_speed_percent = r_speed_percent;
        n_pct           = '{default: lfmc_pkg::PCT_ZERO};
        n_mode          = lfmc_pkg::MODE_SPIN;
        if (r_recovering) begin
            // spin toward the stored direction; exit on the opposite turn
            if (r_turn_memory) begin
                n_pct.lf = lfmc_pkg::PCT_HALF;
                n_pct.rr = lfmc_pkg::PCT_HALF;
            end else begin
                n_pct.lr = lfmc_pkg::PCT_HALF;
                n_pct.rf = lfmc_pkg::PCT_HALF;
            end
            if ((r_turn_memory && w_left_pat) || (!r_turn_memory && w_right_pat)) begin
                n_turn_memory   = ~r_turn_memory;
                n_speed_percent = i_resume_percent;
                n_recovering    = 1'b0;
            end
        end else begin
            case (w_pat)
                lfmc_pkg::PAT_RIGHT_SHARP: begin
                    n_pct.lf        = lfmc_pkg::PCT_FULL;
                    n_pct.rr        = lfmc_pkg::PCT_TENTH;
                    n_mode          = lfmc_pkg::MODE_TURN;
                    n_turn_memory   = 1'b1;
                    n_speed_percent = i_resume_percent;
                end
                lfmc_pkg::PAT_RIGHT_SOFT: begin
                    n_pct.lf        = lfmc_pkg::PCT_NINE;
                    n_pct.rr        = lfmc_pkg::PCT_HALF;
                    n_mode          = lfmc_pkg::MODE_TURN;
                    n_turn_memory   = 1'b1;
                    n_speed_percent = i_resume_percent;
                end
                lfmc_pkg::PAT_LEFT_SHARP: begin
                    n_pct.lr        = lfmc_pkg::PCT_TENTH;
                    n_pct.rf        = lfmc_pkg::PCT_FULL;
                    n_mode          = lfmc_pkg::MODE_TURN;
                    n_turn_memory   = 1'b0;
                    n_speed_percent = i_resume_percent;
                end
                lfmc_pkg::PAT_LEFT_SOFT: begin
                    n_pct.lr        = lfmc_pkg::PCT_HALF;
                    n_pct.rf        = lfmc_pkg::PCT_NINE;
                    n_mode          = lfmc_pkg::MODE_TURN;
                    n_turn_memory   = 1'b0;
                    n_speed_percent = i_resume_percent;
                end
                lfmc_pkg::PAT_LOST: begin
                    n_recovering = 1'b1;
                    if (r_turn_memory) begin
                        n_pct.lf = lfmc_pkg::PCT_HALF;
                        n_pct.rr = lfmc_pkg::PCT_HALF;
                    end else begin
                        n_pct.lr = lfmc_pkg::PCT_HALF;
                        n_pct.rf = lfmc_pkg::PCT_HALF;
                    end
                end
                default: begin
                    // cruise, ramping speed one percent per tick
                    n_pct.lf = r_speed_percent;
                    n_pct.rf = r_speed_percent;
                    n_mode   = lfmc_pkg::MODE_CRUISE;
                    if (r_speed_percent <= lfmc_pkg::PCT_RAMP_TOP) begin
                        n_speed_percent = r_speed_percent + 7'd1;
                    end
                end
            endcase
        end
    end

    // Drive state advances once per accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_turn_memory   <= 1'b1;
            r_recovering    <= 1'b0;
            r_speed_percent <= 7'd0;
        end else if (i_accept) begin
            r_turn_memory   <= n_turn_memory;
            r_recovering    <= n_recovering;
            r_speed_percent <= n_speed_percent;
        end
    end

    // Stage register for the selected percents
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_pct  <= n_pct;
            r_mode <= n_mode;
        end
    end

    assign o_pct  = r_pct;
    assign o_mode = r_mode;

endmodule

/* hw/rtl/lfmc_duty_lane.sv */
// One duty channel: period times percent, divide by 100, clamp to period.
module lfmc_duty_lane (
    input  logic                i_clk,
    input  lfmc_pkg::t_lane_ctl i_ctl,
    input  logic [15:0]         i_pwm_period,
    input  logic [6:0]          i_pct,
    output logic [15:0]         o_duty
);

    logic [22:0] r_prod;
    logic [15:0] r_duty;
    logic [46:0] w_scaled;
    logic [16:0] w_quot;
    logic [15:0] n_duty;

    // Divide by 100 through the reciprocal, then saturate at the period
    assign w_scaled = 47'(r_prod) * 47'(lfmc_pkg::DIV_RECIP);
    assign w_quot   = w_scaled[lfmc_pkg::DIV_SHIFT +: 17];
    assign n_duty   = (w_quot > {1'b0, i_pwm_period}) ? i_pwm_period : w_quot[15:0];

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_prod) begin
            r_prod <= 23'(i_pwm_period) * 23'(i_pct);
        end
        if (i_ctl.load_duty) begin
            r_duty <= n_duty;
        end
    end

    assign o_duty = r_duty;

endmodule

/* hw/rtl/line_follower_motor_control_unit.sv */
// Top level of the line follower motor control unit.
// Each input transaction carries one tick's three line-sensor bits and yields
// one result transaction with four PWM compare values and the drive mode. The
// path is three register stages deep (decode, period x percent product,
// divide by 100 and clamp). Results wait in the last stage for m_axis_tready.
// A new tick can be accepted every cycle unless all stages are full and the
// output is stalled. Each stage moves up as soon as the stage after it is
// empty or draining, so bubbles close up and input keeps flowing while a
// result waits. Configuration is taken through a plain write port and should
// only change while no tick is in flight. No reset clearing pass is needed.
module line_follower_motor_control_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [0] sensor_left, [1] sensor_middle, [2] sensor_right, [7:3] zero
    input  logic [7:0]  s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [15:0] left_forward_duty, [31:16] left_reverse_duty,
    // [47:32] right_forward_duty, [63:48] right_reverse_duty,
    // [65:64] drive_mode, [71:66] zero
    output logic [71:0] m_axis_tdata,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_wdata
);

    logic [15:0]         r_pwm_period;
    logic [6:0]          r_resume_percent;
    logic                r_v1;
    logic                r_v2;
    logic                r_v3;
    lfmc_pkg::t_mode     r_mode2;
    lfmc_pkg::t_mode     r_mode3;
    logic                w_en1;
    logic                w_en2;
    logic                w_en3;
    logic                w_accept;
    lfmc_pkg::t_lane_ctl w_ctl;
    lfmc_pkg::t_pct_set  w_pct;
    lfmc_pkg::t_mode     w_mode1;
    logic [15:0]         w_lf;
    logic [15:0]         w_lr;
    logic [15:0]         w_rf;
    logic [15:0]         w_rr;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pwm_period     <= lfmc_pkg::PWM_PERIOD_RST;
            r_resume_percent <= lfmc_pkg::RESUME_PERCENT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                lfmc_pkg::REG_PWM_PERIOD:     r_pwm_period     <= i_cfg_wdata;
                lfmc_pkg::REG_RESUME_PERCENT: r_resume_percent <= i_cfg_wdata[6:0];
                default: ;
            endcase
        end
    end

    // Stage enables: advance when the next stage is empty or moving
    assign w_en3         = !r_v3 || m_axis_tready;
    assign w_en2         = !r_v2 || w_en3;
    assign w_en1         = !r_v1 || w_en2;
    assign s_axis_tready = w_en1;
    assign w_accept      = s_axis_tvalid && w_en1;
    assign w_ctl.load_prod = w_en2 && r_v1;
    assign w_ctl.load_duty = w_en3 && r_v2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_en1) r_v1 <= w_accept;
            if (w_en2) r_v2 <= r_v1;
            if (w_en3) r_v3 <= r_v2;
        end
    end

    // Carry the mode alongside the duty lanes
    always_ff @(posedge i_clk) begin
        if (w_ctl.load_prod) r_mode2 <= w_mode1;
        if (w_ctl.load_duty) r_mode3 <= r_mode2;
    end

    lfmc_decode u_decode (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (w_accept),
        .i_sensor_left    (s_axis_tdata[0]),
        .i_sensor_middle  (s_axis_tdata[1]),
        .i_sensor_right   (s_axis_tdata[2]),
        .i_resume_percent (r_resume_percent),
        .o_pct            (w_pct),
        .o_mode           (w_mode1)
    );

    lfmc_duty_lane u_lane_lf (
        .i_clk (i_clk), .i_ctl (w_ctl), .i_pwm_period (r_pwm_period),
        .i_pct (w_pct.lf), .o_duty (w_lf)
    );

    lfmc_duty_lane u_lane_lr (
        .i_clk (i_clk), .i_ctl (w_ctl), .i_pwm_period (r_pwm_period),
        .i_pct (w_pct.lr), .o_duty (w_lr)
    );

    lfmc_duty_lane u_lane_rf (
        .i_clk (i_clk), .i_ctl (w_ctl), .i_pwm_period (r_pwm_period),
        .i_pct (w_pct.rf), .o_duty (w_rf)
    );

    lfmc_duty_lane u_lane_rr (
        .i_clk (i_clk), .i_ctl (w_ctl), .i_pwm_period (r_pwm_period),
        .i_pct (w_pct.rr), .o_duty (w_rr)
    );

    assign m_axis_tvalid = r_v3;
    assign m_axis_tdata  = {6'd0, r_mode3, w_rr, w_rf, w_lr, w_lf};

    // Spin drives one diagonal pair at equal duty
    a_spin_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (r_mode3 == lfmc_pkg::MODE_SPIN)) |->
            ((w_lf == w_rr) && (w_lr == w_rf) && ((w_lf == 16'd0) || (w_lr == 16'd0))))
        else $error("spin duties not a matched diagonal pair");

    // Cruise drives both forward channels equally, no reverse
    a_cruise_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (r_mode3 == lfmc_pkg::MODE_CRUISE)) |->
            ((w_lf == w_rf) && (w_lr == 16'd0) && (w_rr == 16'd0)))
        else $error("cruise duties inconsistent");

    // A turn uses only one diagonal pair
    a_turn_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (r_mode3 == lfmc_pkg::MODE_TURN)) |->
            (((w_lr == 16'd0) && (w_rf == 16'd0)) || ((w_lf == 16'd0) && (w_rr == 16'd0))))
        else $error("turn duties drive both diagonals");

endmodule

/* tb/sv/line_follower_motor_control_unit_tb.sv */
// Testbench for the line follower motor control unit: duty prediction and stream checks.
`timescale 1ns / 1ps

module line_follower_motor_control_unit_tb;

    localparam int CLK_HALF      = 2;
    localparam int RESET_CYCLES  = 11;
    localparam int MAX_WAIT      = 12;
    localparam int STALL_LIMIT   = 2000;
    localparam int PHASE_TICKS   = 180;
    localparam int SETTLE_CYCLES = 8;

    // Cruise patterns, written {left, middle, right}
    localparam logic [2:0] PAT_CRUISE_MID   = 3'b010;
    localparam logic [2:0] PAT_CRUISE_EDGES = 3'b101;
    localparam logic [2:0] PAT_CRUISE_ALL   = 3'b111;

    // One expected result transaction
    typedef struct packed {
        logic [15:0]     lf;
        logic [15:0]     lr;
        logic [15:0]     rf;
        logic [15:0]     rr;
        lfmc_pkg::t_mode mode;
    } t_duty_set;

    // Tracks controller state and checks each result against the oldest expectation
    class t_duty_scoreboard;
        logic [15:0] period;
        logic [6:0]  resume;
        logic [6:0]  speed;
        bit          turn_right;
        bit          spinning;
        t_duty_set   expected_q[$];
        int          errors;

        function new();
            period     = lfmc_pkg::PWM_PERIOD_RST;
            resume     = lfmc_pkg::RESUME_PERCENT_RST;
            speed      = '0;
            turn_right = 1'b1;
            spinning   = 1'b0;
            errors     = 0;
        endfunction

        function void write_reg(logic [0:0] idx, logic [15:0] value);
            if (idx == lfmc_pkg::REG_PWM_PERIOD) begin
                period = value;
            end else begin
                resume = value[6:0];
            end
        endfunction

        function logic [15:0] duty_of_pct(logic [6:0] pct);
            int unsigned prod;
            prod = int'(period) * int'(pct);
            return 16'(prod / 100);
        endfunction

        function t_duty_set spin_set(bit dir_right);
            t_duty_set e;
            logic [15:0] half;
            half = duty_of_pct(lfmc_pkg::PCT_HALF);
            e = '{lf: 16'd0, lr: 16'd0, rf: 16'd0, rr: 16'd0, mode: lfmc_pkg::MODE_SPIN};
            if (dir_right) begin
                e.lf = half;
                e.rr = half;
            end else begin
                e.lr = half;
                e.rf = half;
            end
            return e;
        endfunction

        // Advance the controller by one accepted tick and queue its result
        function void note_tick(logic [2:0] pat);
            t_duty_set e;
            bit right_pat;
            bit left_pat;
            int unsigned d;
            right_pat = (pat == lfmc_pkg::PAT_RIGHT_SHARP) ||
                        (pat == lfmc_pkg::PAT_RIGHT_SOFT);
            left_pat  = (pat == lfmc_pkg::PAT_LEFT_SHARP) ||
                        (pat == lfmc_pkg::PAT_LEFT_SOFT);
            e = '{lf: 16'd0, lr: 16'd0, rf: 16'd0, rr: 16'd0, mode: lfmc_pkg::MODE_TURN};
            if (spinning) begin
                e = spin_set(turn_right);
                if ((turn_right && left_pat) || (!turn_right && right_pat)) begin
                    turn_right = !turn_right;
                    speed      = resume;
                    spinning   = 1'b0;
                end
            end else begin
                case (pat)
                    lfmc_pkg::PAT_RIGHT_SHARP: begin
                        e.lf = duty_of_pct(lfmc_pkg::PCT_FULL);
                        e.rr = duty_of_pct(lfmc_pkg::PCT_TENTH);
                    end
                    lfmc_pkg::PAT_RIGHT_SOFT: begin
                        e.lf = duty_of_pct(lfmc_pkg::PCT_NINE);
                        e.rr = duty_of_pct(lfmc_pkg::PCT_HALF);
                    end
                    lfmc_pkg::PAT_LEFT_SHARP: begin
                        e.lr = duty_of_pct(lfmc_pkg::PCT_TENTH);
                        e.rf = duty_of_pct(lfmc_pkg::PCT_FULL);
                    end
                    lfmc_pkg::PAT_LEFT_SOFT: begin
                        e.lr = duty_of_pct(lfmc_pkg::PCT_HALF);
                        e.rf = duty_of_pct(lfmc_pkg::PCT_NINE);
                    end
                    lfmc_pkg::PAT_LOST: begin
                        spinning = 1'b1;
                        e = spin_set(turn_right);
                    end
                    default: begin
                        // Cruise: saturate at the period, ramp up to 101
                        d = (int'(period) * int'(speed)) / 100;
                        if (d > period) begin
                            d = period;
                        end
                        e.lf   = d[15:0];
                        e.rf   = d[15:0];
                        e.mode = lfmc_pkg::MODE_CRUISE;
                        if (speed <= lfmc_pkg::PCT_RAMP_TOP) begin
                            speed = speed + 7'd1;
                        end
                    end
                endcase
                if (right_pat) begin
                    turn_right = 1'b1;
                    speed      = resume;
                end else if (left_pat) begin
                    turn_right = 1'b0;
                    speed      = resume;
                end
            end
            expected_q.push_back(e);
        endfunction

        function void compare_field(string name, logic [15:0] exp_val, logic [15:0] act_val);
            if (exp_val !== act_val) begin
                errors++;
                $display("%0t: %s mismatch: expected %0d, actual %0d",
                         $time, name, exp_val, act_val);
            end
        endfunction

        function void check_result(logic [71:0] data);
            t_duty_set e;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: result with nothing expected: expected none, actual %h",
                         $time, data);
                return;
            end
            e = expected_q.pop_front();
            compare_field("left_forward_duty", e.lf, data[15:0]);
            compare_field("left_reverse_duty", e.lr, data[31:16]);
            compare_field("right_forward_duty", e.rf, data[47:32]);
            compare_field("right_reverse_duty", e.rr, data[63:48]);
            compare_field("drive_mode", 16'(e.mode), 16'(data[65:64]));
            compare_field("tdata padding", 16'd0, 16'(data[71:66]));
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;
    logic        i_cfg_we;
    logic [0:0]  i_cfg_idx;
    logic [15:0] i_cfg_wdata;

    t_duty_scoreboard sb;
    int  ticks_sent;
    int  idle_cycles;
    bit  sender_burst;
    bit  sink_burst;

    line_follower_motor_control_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    // Generate clock
    initial i_clk = 1'b0;
    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // Draw a wait, with occasional stretches of back-to-back traffic
    function automatic int draw_wait(ref bit burst);
        if ($urandom_range(0, 15) == 0) begin
            burst = !burst;
        end
        return burst ? 0 : int'($urandom_range(0, MAX_WAIT));
    endfunction

    // Send one tick and note it once the transaction completes
    task automatic send_tick(logic [2:0] pat);
        int gap;
        gap = draw_wait(sender_burst);
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tdata  = {5'b0, pat[0], pat[1], pat[2]};
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_tick(pat);
        ticks_sent++;
    endtask

    // Drop valid and hold until every expected result has come back
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [0:0] idx, logic [15:0] value);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_idx   = idx;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        sb.write_reg(idx, value);
    endtask

    function automatic logic [2:0] pick_cruise();
        case ($urandom_range(0, 2))
            0:       return PAT_CRUISE_MID;
            1:       return PAT_CRUISE_EDGES;
            default: return PAT_CRUISE_ALL;
        endcase
    endfunction

    function automatic logic [2:0] pick_turn(bit right_side);
        if (right_side) begin
            return $urandom_range(0, 1) ? lfmc_pkg::PAT_RIGHT_SHARP : lfmc_pkg::PAT_RIGHT_SOFT;
        end
        return $urandom_range(0, 1) ? lfmc_pkg::PAT_LEFT_SHARP : lfmc_pkg::PAT_LEFT_SOFT;
    endfunction

    // Send one stretch of line-following behavior: cruise, turns, loss and recovery, or noise
    task automatic run_segment();
        int kind;
        int len;
        kind = $urandom_range(0, 9);
        if (kind <= 3) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 130) : $urandom_range(1, 10);
            repeat (len) send_tick(pick_cruise());
        end else if (kind <= 5) begin
            repeat ($urandom_range(1, 4)) send_tick(pick_turn(1'($urandom_range(0, 1))));
        end else if (kind <= 7) begin
            send_tick(lfmc_pkg::PAT_LOST);
            repeat ($urandom_range(0, 6)) send_tick(3'($urandom_range(0, 7)));
            send_tick(pick_turn(!sb.turn_right));
        end else begin
            repeat ($urandom_range(1, 6)) send_tick(3'($urandom_range(0, 7)));
        end
        // Occasionally let the pipeline empty completely
        if ($urandom_range(0, 39) == 0) begin
            drain();
        end
    endtask

    // Accept results with random stalls and check each one
    initial begin
        int stall;
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            stall = draw_wait(sink_burst);
            @(negedge i_clk);
            if (stall > 0) begin
                m_axis_tready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready = 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            sb.check_result(m_axis_tdata);
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Main stimulus
    initial begin
        logic [2:0]  directed_pats[];
        logic [15:0] period_set[];
        logic [15:0] resume_set[];
        int target;

        directed_pats = '{
            PAT_CRUISE_MID, PAT_CRUISE_EDGES, PAT_CRUISE_ALL,
            lfmc_pkg::PAT_RIGHT_SHARP, lfmc_pkg::PAT_RIGHT_SOFT, lfmc_pkg::PAT_LOST,
            lfmc_pkg::PAT_RIGHT_SHARP, PAT_CRUISE_ALL,
            lfmc_pkg::PAT_LEFT_SHARP, PAT_CRUISE_MID, lfmc_pkg::PAT_LEFT_SOFT,
            lfmc_pkg::PAT_LEFT_SHARP,
            lfmc_pkg::PAT_LOST, lfmc_pkg::PAT_LOST, lfmc_pkg::PAT_LEFT_SOFT,
            lfmc_pkg::PAT_RIGHT_SOFT, PAT_CRUISE_EDGES,
            lfmc_pkg::PAT_LOST, lfmc_pkg::PAT_LEFT_SHARP, PAT_CRUISE_ALL
        };
        period_set = '{16'd0, 16'd65535, 16'd1, 16'd100, 16'd0, 16'd65535};
        resume_set = '{16'hFF65, 16'h007F, 16'h0000, 16'h0064, 16'd0, 16'd101};

        sb            = new();
        ticks_sent    = 0;
        sender_burst  = 1'b0;
        sink_burst    = 1'b0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = lfmc_pkg::REG_PWM_PERIOD;
        i_cfg_wdata   = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed ticks at reset settings: every pattern, both spins and exits
        foreach (directed_pats[k]) begin
            send_tick(directed_pats[k]);
        end
        target = ticks_sent + PHASE_TICKS;
        while (ticks_sent < target) run_segment();

        // Random phases over register extremes and random settings
        for (int ph = 0; ph < $size(period_set); ph++) begin
            drain();
            if (ph == 4) begin
                period_set[ph] = 16'($urandom_range(1, 65535));
                resume_set[ph] = 16'($urandom_range(0, 65535));
            end
            write_cfg(lfmc_pkg::REG_PWM_PERIOD, period_set[ph]);
            write_cfg(lfmc_pkg::REG_RESUME_PERCENT, resume_set[ph]);
            target = ticks_sent + PHASE_TICKS;
            while (ticks_sent < target) run_segment();
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
